>>> sv/mpmq_pkg.sv
// Package with types, codes and constants of the multi-policy message queue.
package mpmq_pkg;

  localparam int DefReadyDepth  = 16;
  localparam int DefFlightDepth = 16;

  localparam int EntryWidth = 160;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_ACK  = 2'd2,
    ACT_NACK = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FULL        = 3'd1,
    ST_BUSY        = 3'd2,
    ST_EMPTY       = 3'd3,
    ST_NOT_FOUND   = 3'd4,
    ST_UNSUPPORTED = 3'd5,
    ST_NO_SPACE    = 3'd6
  } status_t;

  localparam logic [2:0] POL_LIFO     = 3'd1;
  localparam logic [2:0] POL_PRIORITY = 3'd2;
  localparam logic [2:0] POL_RING     = 3'd3;
  localparam logic [2:0] POL_WORK     = 3'd4;

  localparam logic [2:0] BP_DROP_NEW  = 3'd0;
  localparam logic [2:0] BP_BLOCK     = 3'd1;
  localparam logic [2:0] BP_DROP_OLD  = 3'd2;
  localparam logic [2:0] BP_OVERWRITE = 3'd3;
  localparam logic [2:0] BP_SPILL     = 3'd4;
  localparam logic [2:0] BP_EXPAND    = 3'd5;

  localparam logic [1:0] REG_POLICY   = 2'd0;
  localparam logic [1:0] REG_BACKPR   = 2'd1;
  localparam logic [1:0] REG_CAPACITY = 2'd2;

  // An entry packs seq, id, priority and checksum from the lowest bit up.
  typedef struct packed {
    logic [31:0] checksum;
    logic [31:0] priority_v;
    logic [31:0] id;
    logic [63:0] seq;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN_REQ,
    S_SCAN_CHK,
    S_SHIFT_REQ,
    S_SHIFT_WR,
    S_INS_REQ,
    S_INS_WR,
    S_FL_WR,
    S_NACK_RD,
    S_NACK_WAIT,
    S_DONE
  } state_t;

  // Request to one entry store: one write and one read port.
  typedef struct packed {
    logic   we;
    logic [7:0] waddr;
    entry_t wdata;
    logic [7:0] raddr;
  } mem_req_t;

endpackage

>>> sv/mpmq_store.sv
// Entry store with one write port and one registered read port.
module mpmq_store
  import mpmq_pkg::*;
#(
  parameter int Depth = DefReadyDepth
) (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

>>> sv/mpmq_seq.sv
// Sequencer that walks the stores one entry at a time.
module mpmq_seq
  import mpmq_pkg::*;
#(
  parameter int ReadyDepth  = DefReadyDepth,
  parameter int FlightDepth = DefFlightDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [1:0]   action,
  input  entry_t       in_entry,
  input  logic [31:0]  target_id,
  input  logic [2:0]   queue_policy,
  input  logic [2:0]   backpressure_mode,
  input  logic [4:0]   capacity_limit,
  input  entry_t       rd_rdata,
  input  entry_t       fl_rdata,
  output mem_req_t     rd_req,
  output mem_req_t     fl_req,
  output logic         idle,
  output logic         done,
  output logic [2:0]   res_status,
  output entry_t       res_entry,
  output logic [5:0]   res_depth
);

  localparam int RW = $clog2(ReadyDepth + 1);
  localparam int FW = $clog2(FlightDepth + 1);

  state_t state, state_next;
  logic [RW-1:0] ready_count, ready_count_next;
  logic [FW-1:0] flight_count, flight_count_next;
  logic [31:0]   next_id, next_id_next;
  logic [1:0]    act, act_next;
  entry_t        item, item_next;
  logic [31:0]   tgt, tgt_next;
  logic [8:0]    idx, idx_next;
  logic [8:0]    best, best_next;
  logic [31:0]   best_prio, best_prio_next;
  logic [8:0]    lim, lim_next;
  logic          remove_mode, remove_mode_next;
  logic          found, found_next;
  logic [2:0]    status, status_next;
  entry_t        held, held_next;

  logic at_limit;
  logic work;
  logic new_best;
  logic [8:0] rc9, fc9;

  assign rc9 = 9'(ready_count);
  assign fc9 = 9'(flight_count);
  assign work = (queue_policy == POL_WORK);
  assign at_limit = (capacity_limit != 5'd0) && (rc9 >= 9'(capacity_limit));
  assign new_best = (idx == 9'd0) || (rd_rdata.priority_v > best_prio);
  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);
  assign res_status = status;
  assign res_entry = held;
  assign res_depth = work ? 6'(rc9 + fc9) : 6'(rc9);

  always_comb begin
    state_next = state;
    ready_count_next = ready_count;
    flight_count_next = flight_count;
    next_id_next = next_id;
    act_next = act;
    item_next = item;
    tgt_next = tgt;
    idx_next = idx;
    best_next = best;
    best_prio_next = best_prio;
    lim_next = lim;
    remove_mode_next = remove_mode;
    found_next = found;
    status_next = status;
    held_next = held;
    case (state)
      S_IDLE: begin
        if (start) begin
          act_next = action;
          item_next = in_entry;
          item_next.id = next_id;
          tgt_next = target_id;
          held_next = '0;
          status_next = ST_OK;
          state_next = S_DECIDE;
          if (action == ACT_PUSH) next_id_next = next_id + 32'd1;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
        idx_next = '0;
        best_next = '0;
        best_prio_next = '0;
        case (act)
          ACT_PUSH: begin
            if (at_limit && queue_policy != POL_RING &&
                (backpressure_mode == BP_DROP_NEW ||
                 backpressure_mode > BP_EXPAND)) begin
              status_next = ST_FULL;
            end else if (at_limit && queue_policy != POL_RING &&
                         backpressure_mode == BP_BLOCK) begin
              status_next = ST_BUSY;
            end else if (at_limit && (queue_policy == POL_RING ||
                         backpressure_mode == BP_DROP_OLD ||
                         backpressure_mode == BP_OVERWRITE)) begin
              // Drop the oldest, then append at the end.
              remove_mode_next = 1'b0;
              lim_next = rc9;
              found_next = 1'b0;
              state_next = S_SHIFT_REQ;
            end else if (rc9 >= 9'(ReadyDepth)) begin
              status_next = ST_NO_SPACE;
            end else begin
              found_next = 1'b0;
              idx_next = rc9;
              held_next = item;
              state_next = S_INS_WR;
            end
          end
          ACT_POP: begin
            if (rc9 == 9'd0) status_next = ST_EMPTY;
            else if (work && fc9 >= 9'(FlightDepth)) status_next = ST_NO_SPACE;
            else if (queue_policy == POL_PRIORITY) begin
              lim_next = rc9;
              state_next = S_SCAN_REQ;
            end else begin
              best_next = (queue_policy == POL_LIFO) ? rc9 - 9'd1 : 9'd0;
              idx_next = (queue_policy == POL_LIFO) ? rc9 - 9'd1 : 9'd0;
              lim_next = rc9;
              state_next = S_SCAN_REQ;
            end
          end
          default: begin
            if (!work) status_next = ST_UNSUPPORTED;
            else begin
              lim_next = fc9;
              found_next = 1'b0;
              state_next = S_SCAN_REQ;
            end
          end
        endcase
      end
      S_SCAN_REQ: begin
        if (act != ACT_POP && idx >= lim) begin
          status_next = ST_NOT_FOUND;
          state_next = S_DONE;
        end else state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        state_next = S_SCAN_REQ;
        if (act == ACT_POP) begin
          if (queue_policy == POL_PRIORITY) begin
            if (new_best) begin
              best_next = idx;
              best_prio_next = rd_rdata.priority_v;
              held_next = rd_rdata;
            end
            if (idx + 9'd1 >= lim) begin
              idx_next = new_best ? idx : best;
              remove_mode_next = 1'b0;
              state_next = work ? S_FL_WR : S_SHIFT_REQ;
            end else idx_next = idx + 9'd1;
          end else begin
            held_next = rd_rdata;
            remove_mode_next = 1'b0;
            state_next = work ? S_FL_WR : S_SHIFT_REQ;
          end
        end else if (fl_rdata.id == tgt) begin
          best_next = idx;
          if (act == ACT_NACK && rc9 >= 9'(ReadyDepth)) begin
            status_next = ST_NO_SPACE;
            state_next = S_DONE;
          end else if (act == ACT_NACK) begin
            state_next = S_NACK_RD;
          end else begin
            remove_mode_next = 1'b1;
            state_next = S_SHIFT_REQ;
          end
        end else idx_next = idx + 9'd1;
      end
      S_FL_WR: begin
        flight_count_next = FW'(fc9 + 9'd1);
        state_next = S_SHIFT_REQ;
      end
      S_SHIFT_REQ: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (idx + 9'd1 < lim) begin
          idx_next = idx + 9'd1;
          state_next = S_SHIFT_REQ;
        end else begin
          if (remove_mode) flight_count_next = FW'(fc9 - 9'd1);
          else ready_count_next = RW'(rc9 - 9'd1);
          if (act == ACT_PUSH) begin
            held_next = item;
            idx_next = rc9 - 9'd1;
            state_next = S_INS_WR;
          end else state_next = S_DONE;
        end
      end
      S_NACK_RD: state_next = S_NACK_WAIT;
      S_NACK_WAIT: begin
        held_next = fl_rdata;
        idx_next = rc9;
        found_next = 1'b1;
        state_next = (rc9 == 9'd0) ? S_INS_WR : S_INS_REQ;
      end
      S_INS_REQ: state_next = S_INS_WR;
      S_INS_WR: begin
        if (!found || idx == 9'd0) begin
          ready_count_next = RW'(rc9 + 9'd1);
          held_next = '0;
          if (act == ACT_NACK) begin
            remove_mode_next = 1'b1;
            idx_next = best;
            lim_next = fc9;
            state_next = S_SHIFT_REQ;
          end else begin
            state_next = S_DONE;
          end
        end else begin
          idx_next = idx - 9'd1;
          state_next = (idx == 9'd1) ? S_INS_WR : S_INS_REQ;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory requests per state.
  always_comb begin
    rd_req = '0;
    fl_req = '0;
    case (state)
      S_SCAN_REQ: begin
        rd_req.raddr = 8'(idx);
        fl_req.raddr = 8'(idx);
      end
      S_SHIFT_REQ: begin
        rd_req.raddr = 8'(idx + 9'd1);
        fl_req.raddr = 8'(idx + 9'd1);
      end
      S_SHIFT_WR: begin
        if (remove_mode) begin
          fl_req.we = (idx + 9'd1 < lim);
          fl_req.waddr = 8'(idx);
          fl_req.wdata = fl_rdata;
        end else begin
          rd_req.we = (idx + 9'd1 < lim);
          rd_req.waddr = 8'(idx);
          rd_req.wdata = rd_rdata;
        end
      end
      S_INS_REQ: rd_req.raddr = 8'(idx - 9'd1);
      S_INS_WR: begin
        rd_req.we = 1'b1;
        rd_req.waddr = 8'(idx);
        rd_req.wdata = (!found || idx == 9'd0) ? held : rd_rdata;
      end
      S_FL_WR: begin
        fl_req.we = 1'b1;
        fl_req.waddr = 8'(fc9);
        fl_req.wdata = held;
      end
      S_NACK_RD: fl_req.raddr = 8'(best);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready_count <= '0;
      flight_count <= '0;
      next_id <= 32'd1;
    end else begin
      state <= state_next;
      ready_count <= ready_count_next;
      flight_count <= flight_count_next;
      next_id <= next_id_next;
    end
  end

  always_ff @(posedge clk) begin
    act <= act_next;
    item <= item_next;
    tgt <= tgt_next;
    idx <= idx_next;
    best <= best_next;
    best_prio <= best_prio_next;
    lim <= lim_next;
    remove_mode <= remove_mode_next;
    found <= found_next;
    status <= status_next;
    held <= held_next;
  end

endmodule

>>> sv/multi_policy_message_queue.sv
// Top level of the multi-policy message queue.
// Requests enter on the s_axis channel: action, message fields and a target id.
// Each request gives exactly one result on the m_axis channel: a status, the
// popped message (zero unless a pop succeeds) and the queue depth afterwards.
// Registers are written on the cfg channel by index: 0 policy, 1 backpressure
// mode, 2 capacity limit; write them only while the queue is idle.
// The block takes one request at a time. A request that walks the ready or
// in-flight store visits its entries one at a time, as each store has a
// single read port. A nack walks the in-flight store, then the ready store to
// open the head, then the in-flight store again to close the gap.
// Reset empties both stores, sets the next id to one and the registers to zero.
// A result waits in an output register until m_axis_tready; s_axis_tready stays
// low until then.
module multi_policy_message_queue
  import mpmq_pkg::*;
#(
  parameter int READY_DEPTH  = DefReadyDepth,
  parameter int FLIGHT_DEPTH = DefFlightDepth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action, msg_seq_in, msg_priority_in, msg_checksum_in, target_id, pad
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, msg_seq_out, msg_id_out, msg_priority_out, msg_checksum_out,
  // queue_depth, pad
  output logic [175:0] m_axis_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [4:0]   cfg_data
);

  logic [2:0] queue_policy;
  logic [2:0] backpressure_mode;
  logic [4:0] capacity_limit;
  mem_req_t rd_req, fl_req;
  entry_t rd_rdata, fl_rdata, res_entry, in_entry;
  logic idle, done, start;
  logic [2:0] res_status;
  logic [5:0] res_depth;
  logic out_full;

  assign cfg_ready = 1'b1;
  assign s_axis_tready = idle && !out_full;
  assign start = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_full;

  assign in_entry.seq = s_axis_tdata[65:2];
  assign in_entry.priority_v = s_axis_tdata[97:66];
  assign in_entry.checksum = s_axis_tdata[129:98];
  assign in_entry.id = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_policy <= '0;
      backpressure_mode <= '0;
      capacity_limit <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POLICY:   queue_policy <= cfg_data[2:0];
        REG_BACKPR:   backpressure_mode <= cfg_data[2:0];
        REG_CAPACITY: capacity_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (done) begin
      out_full <= 1'b1;
    end else if (m_axis_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      m_axis_tdata <= {7'd0, res_depth, res_entry.checksum, res_entry.priority_v,
                       res_entry.id, res_entry.seq, res_status};
    end
  end

  mpmq_store #(.Depth(READY_DEPTH)) u_ready (
    .clk(clk), .req(rd_req), .rdata(rd_rdata)
  );

  mpmq_store #(.Depth(FLIGHT_DEPTH)) u_flight (
    .clk(clk), .req(fl_req), .rdata(fl_rdata)
  );

  mpmq_seq #(.ReadyDepth(READY_DEPTH), .FlightDepth(FLIGHT_DEPTH)) u_seq (
    .clk(clk), .rst(rst), .start(start), .action(s_axis_tdata[1:0]),
    .in_entry(in_entry), .target_id(s_axis_tdata[161:130]),
    .queue_policy(queue_policy), .backpressure_mode(backpressure_mode),
    .capacity_limit(capacity_limit), .rd_rdata(rd_rdata), .fl_rdata(fl_rdata),
    .rd_req(rd_req), .fl_req(fl_req), .idle(idle), .done(done),
    .res_status(res_status), .res_entry(res_entry), .res_depth(res_depth)
  );

endmodule

>>> sv/mpmq_checker.sv
// Port checker for the message queue, bound to the top level.
module mpmq_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [175:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("Request taken while a result waits.");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Request taken while busy.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] != 3'd7)
    else $error("Undefined status code.");

endmodule

bind multi_policy_message_queue mpmq_checker u_chk (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
